[src/i2cmbe_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the byte-level I2C master engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

  // Command codes carried in the op field; also the engine's current command.
  typedef enum logic [2:0] {
    KIND_IDLE  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned QP_W      = 16;

  // Register index is paddr[2]; only index 0 exists.
  localparam logic        REG_QUARTER_PERIOD = 1'b0;
  localparam logic [QP_W-1:0] QP_RESET       = 16'd250;

  localparam logic [3:0]  DATA_BITS = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_nak;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nak;
  } res_t;

endpackage

`default_nettype wire

[src/i2cmbe_regs.sv]
// ----------------------------------------------------------------------------
// i2cmbe_regs
// APB register file: holds the quarter-period register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [i2cmbe_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [i2cmbe_pkg::PDATA_W-1:0]  pwdata,
  output logic      [i2cmbe_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [i2cmbe_pkg::QP_W-1:0]     quarter_period
);
  import i2cmbe_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_QUARTER_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_period <= QP_RESET;
    end else if (wr_hit) begin
      quarter_period <= pwdata[QP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_QUARTER_PERIOD) begin
      prdata = {{(PDATA_W-QP_W){1'b0}}, quarter_period};
    end
  end

endmodule

`default_nettype wire

[src/i2cmbe_core.sv]
// ----------------------------------------------------------------------------
// i2cmbe_core
// Quarter-period sequencer: one tick of the engine per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire i2cmbe_pkg::item_t            item,
  input  wire logic [i2cmbe_pkg::QP_W-1:0]  quarter_period,
  output i2cmbe_pkg::res_t                  res
);
  import i2cmbe_pkg::*;

  kind_t            kind, kind_next;
  logic [2:0]       phase, phase_next;
  logic [QP_W-1:0]  qcount, qcount_next;
  logic [3:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             nak_to_send, nak_to_send_next;
  logic             scl_drv, scl_drv_next;
  logic             sda_drv, sda_drv_next;
  logic [7:0]       rx_byte, rx_byte_next;
  logic             ack_seen, ack_seen_next;

  logic [QP_W-1:0]  q_eff;
  logic             done;
  logic             do_enter;
  kind_t            e_kind;
  logic [2:0]       e_phase;
  logic [3:0]       e_bit;
  logic [7:0]       e_shift;
  logic             e_nak;
  logic [2:0]       adv_phase;
  logic [3:0]       adv_bit;
  logic             e_data;

  function automatic logic [2:0] group_len(input kind_t k, input logic [3:0] b);
    logic [2:0] n;
    case (k)
      KIND_START: n = 3'd3;
      KIND_STOP:  n = 3'd2;
      default:    n = (b < DATA_BITS) ? 3'd4 : 3'd5;
    endcase
    return n;
  endfunction

  assign q_eff = (quarter_period == '0) ? QP_W'(1) : quarter_period;

  always_comb begin
    kind_next        = kind;
    phase_next       = phase;
    qcount_next      = qcount;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    nak_to_send_next = nak_to_send;
    scl_drv_next     = scl_drv;
    sda_drv_next     = sda_drv;
    rx_byte_next     = rx_byte;
    ack_seen_next    = ack_seen;
    done             = 1'b0;
    do_enter         = 1'b0;
    e_kind           = kind;
    e_phase          = phase;
    e_bit            = bit_index;
    e_shift          = shift_byte;
    e_nak            = nak_to_send;
    adv_phase        = phase + 3'd1;
    adv_bit          = bit_index;

    if (step) begin
      if (kind == KIND_IDLE) begin
        if ((item.op == KIND_START) || (item.op == KIND_STOP) ||
            (item.op == KIND_WRITE) || (item.op == KIND_READ)) begin
          do_enter    = 1'b1;
          e_kind      = kind_t'(item.op);
          e_phase     = 3'd0;
          e_bit       = 4'd0;
          qcount_next = QP_W'(1);
          if (item.op == KIND_WRITE) begin
            e_shift = item.tx_byte;
          end
          if (item.op == KIND_READ) begin
            e_shift = 8'd0;
            e_nak   = item.send_nak;
          end
        end
      end else if (qcount >= q_eff) begin
        // Advance to the next quarter; wrap to the next bit at group end.
        if ((adv_phase >= group_len(kind, bit_index)) &&
            ((kind == KIND_WRITE) || (kind == KIND_READ)) &&
            (bit_index < DATA_BITS)) begin
          adv_bit   = bit_index + 4'd1;
          adv_phase = 3'd0;
        end
        if (adv_phase >= group_len(kind, adv_bit)) begin
          if (kind == KIND_READ) begin
            sda_drv_next = 1'b0;
            rx_byte_next = shift_byte;
          end
          kind_next      = KIND_IDLE;
          phase_next     = 3'd0;
          bit_index_next = 4'd0;
          qcount_next    = '0;
          done           = 1'b1;
        end else begin
          do_enter    = 1'b1;
          e_phase     = adv_phase;
          e_bit       = adv_bit;
          qcount_next = QP_W'(1);
        end
      end else begin
        qcount_next = qcount + QP_W'(1);
      end
    end

    e_data = (e_bit < DATA_BITS);

    // Line actions at the first tick of a quarter.
    if (do_enter) begin
      kind_next        = e_kind;
      phase_next       = e_phase;
      bit_index_next   = e_bit;
      nak_to_send_next = e_nak;
      shift_byte_next  = e_shift;
      case (e_kind)
        KIND_START: begin
          if (e_phase == 3'd0) begin
            sda_drv_next = 1'b0;
            scl_drv_next = 1'b0;
          end else if (e_phase == 3'd1) begin
            sda_drv_next = 1'b1;
          end else begin
            scl_drv_next = 1'b1;
          end
        end
        KIND_STOP: begin
          if (e_phase == 3'd0) begin
            sda_drv_next = 1'b1;
            scl_drv_next = 1'b0;
          end else begin
            sda_drv_next = 1'b0;
          end
        end
        KIND_WRITE: begin
          if (e_phase == 3'd0) begin
            if (e_data) begin
              sda_drv_next    = ~e_shift[7];
              shift_byte_next = {e_shift[6:0], 1'b0};
            end else begin
              sda_drv_next = 1'b0;
            end
          end else if (e_phase == 3'd1) begin
            scl_drv_next = 1'b0;
          end else if (e_phase == 3'd2) begin
            if (!e_data) begin
              ack_seen_next = item.sda_level;
            end
          end else if (e_phase == 3'd3) begin
            scl_drv_next = 1'b1;
          end
        end
        KIND_READ: begin
          if (e_phase == 3'd0) begin
            if (e_data) begin
              if (e_bit == 4'd0) begin
                sda_drv_next = 1'b0;
              end
            end else begin
              sda_drv_next = ~e_nak;
            end
          end else if (e_phase == 3'd1) begin
            scl_drv_next = 1'b0;
          end else if (e_phase == 3'd2) begin
            if (e_data) begin
              shift_byte_next = {e_shift[6:0], item.sda_level};
            end
          end else if (e_phase == 3'd3) begin
            scl_drv_next = 1'b1;
          end
        end
        default: begin
          scl_drv_next = scl_drv;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= KIND_IDLE;
      phase       <= 3'd0;
      qcount      <= '0;
      bit_index   <= 4'd0;
      shift_byte  <= 8'd0;
      nak_to_send <= 1'b0;
      scl_drv     <= 1'b0;
      sda_drv     <= 1'b0;
      rx_byte     <= 8'd0;
      ack_seen    <= 1'b0;
    end else begin
      kind        <= kind_next;
      phase       <= phase_next;
      qcount      <= qcount_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      nak_to_send <= nak_to_send_next;
      scl_drv     <= scl_drv_next;
      sda_drv     <= sda_drv_next;
      rx_byte     <= rx_byte_next;
      ack_seen    <= ack_seen_next;
    end
  end

  always_comb begin
    res.scl_low   = scl_drv_next;
    res.sda_low   = sda_drv_next;
    res.busy_res  = (kind_next != KIND_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_byte_next;
    res.slave_nak = ack_seen_next;
  end

endmodule

`default_nettype wire

[src/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level open-drain I2C master: one input transfer per engine tick.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+---------------------
//   item     | in        | item_valid / item_ready     | item_t (op, byte, nak, sda)
//   result   | out       | result_valid / result_ready | res_t (lines, status, rx)
//   apb      | in/out    | psel, penable, pwrite       | quarter_period at 0x0
//
// One item is accepted per clock unless the result stalls; each produces
// exactly one result via the input register, then the sequencer tick into
// the result register. The engine state advances only when an item moves on.
// Reset (rst, synchronous) empties both registers and idles the engine with
// both lines released and quarter_period at 250.
// A stalled result holds; item_ready drops only while both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire i2cmbe_pkg::item_t               item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output i2cmbe_pkg::res_t                     result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [i2cmbe_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [i2cmbe_pkg::PDATA_W-1:0]  pwdata,
  output logic      [i2cmbe_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready
);
  import i2cmbe_pkg::*;

  logic              s1_valid;
  item_t             s1_item;
  logic              s1_move;
  res_t              core_res;
  logic [QP_W-1:0]   quarter_period;

  // Move the held item into the engine when the result slot frees up.
  assign s1_move    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_move;

  i2cmbe_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .quarter_period (quarter_period)
  );

  i2cmbe_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (s1_move),
    .item           (s1_item),
    .quarter_period (quarter_period),
    .res            (core_res)
  );

  // Input register: capture on transfer, drop when handed to the engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Result register: load on each engine tick, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result <= core_res;
    end
  end

endmodule

`default_nettype wire

[src/i2cmbe_checker.sv]
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks for the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_valid,
  input wire logic                            item_ready,
  input wire i2cmbe_pkg::item_t               item,
  input wire logic                            result_valid,
  input wire logic                            result_ready,
  input wire i2cmbe_pkg::res_t                result,
  input wire logic                            psel,
  input wire logic                            penable,
  input wire logic                            pwrite,
  input wire logic [i2cmbe_pkg::PADDR_W-1:0]  paddr,
  input wire logic [i2cmbe_pkg::PDATA_W-1:0]  pwdata,
  input wire logic [i2cmbe_pkg::PDATA_W-1:0]  prdata,
  input wire logic                            pready
);
  import i2cmbe_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty result slot");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> !result.busy_res)
    else $error("done reported while still busy");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    $past(psel && penable && pwrite && pready && (paddr[2] == REG_QUARTER_PERIOD)) &&
    !$past(rst) && psel && !pwrite && (paddr[2] == REG_QUARTER_PERIOD)
    |-> prdata[QP_W-1:0] == $past(pwdata[QP_W-1:0]))
    else $error("quarter_period readback mismatch");

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_chk (.*);

`default_nettype wire
